/* src/ctsd_pkg.sv */
`default_nettype none

package ctsd_pkg;

    localparam int NUM_CELLS       = 5;
    localparam int TENTHS_CELL     = 2;
    localparam int SEC_UNITS_CELL  = 3;
    localparam int SEC_TENS_CELL   = 4;
    localparam int MAX_SECONDS_DEF = 64;
    localparam int SEC_WIDTH       = 7;

    localparam logic [7:0] DOT_BIT = 8'h80;

    typedef logic [3:0] bcd_t;
    typedef logic [SEC_WIDTH-1:0] sec_t;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_PAUSE = 2'd2,
        OP_STOP  = 2'd3
    } op_t;

    typedef struct packed {
        logic load;
        logic clear;
    } cell_ctl_t;

    typedef struct packed {
        bcd_t tens;
        bcd_t units;
    } sec_bcd_t;

    function automatic logic [7:0] glyph(input bcd_t d);
        logic [7:0] g;
        unique case (d)
            4'd0:    g = 8'd63;
            4'd1:    g = 8'd6;
            4'd2:    g = 8'd91;
            4'd3:    g = 8'd79;
            4'd4:    g = 8'd102;
            4'd5:    g = 8'd109;
            4'd6:    g = 8'd125;
            4'd7:    g = 8'd7;
            4'd8:    g = 8'd127;
            4'd9:    g = 8'd111;
            default: g = 8'd0;
        endcase
        return g;
    endfunction

    function automatic sec_bcd_t split_seconds(input sec_t v);
        sec_bcd_t r;
        sec_t     tens_val;
        tens_val = '0;
        r.tens   = '0;
        for (int i = 1; i <= 6; i++) begin
            if (v >= sec_t'(i * 10)) begin
                r.tens   = bcd_t'(i);
                tens_val = sec_t'(i * 10);
            end
        end
        r.units = bcd_t'(v - tens_val);
        return r;
    endfunction

endpackage

`default_nettype wire

/* src/ctsd_bcd_cell.sv */
`default_nettype none

module ctsd_bcd_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ctsd_pkg::cell_ctl_t ctl,
    input  wire ctsd_pkg::bcd_t      load_digit,
    input  wire logic                borrow_in,
    output logic                     borrow_out,
    output ctsd_pkg::bcd_t           digit_next,
    output ctsd_pkg::bcd_t           digit
);
    import ctsd_pkg::*;

    bcd_t digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctl.clear)
        begin
            digit_next = '0;
        end
        else if (ctl.load)
        begin
            digit_next = load_digit;
        end
        else if (borrow_in)
        begin
            digit_next = (digit_reg == 4'd0) ? 4'd9 : digit_reg - 4'd1;
        end
    end

    assign borrow_out = borrow_in && (digit_reg == 4'd0);
    assign digit      = digit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

`default_nettype wire

/* src/countdown_timer_seven_segment_core.sv */
// Latency: a word's result is valid in the cycle after it is accepted.
// Throughput: one word per cycle unless out_ready stalls; the millisecond
// count is five BCD cells chained by a combinational borrow; no division.
// Reset: asynchronous, active low; clears the count, flags, digit select,
// segment pattern and the output valid.
`default_nettype none

module countdown_timer_seven_segment_core #(
    parameter int MAX_SECONDS = ctsd_pkg::MAX_SECONDS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [1:0]                   op,
    input  wire logic [ctsd_pkg::SEC_WIDTH-1:0] seconds,
    input  wire logic                         pause_flag,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [7:0]                        segments,
    output logic                              digit_select,
    output logic                              expired
);
    import ctsd_pkg::*;

    logic              accept;
    op_t               op_code;
    cell_ctl_t         ctl;
    sec_t              sec_sat;
    sec_bcd_t          sec_bcd;
    logic [NUM_CELLS:0] borrow;
    bcd_t              load_digit [NUM_CELLS];
    bcd_t              digit_q    [NUM_CELLS];
    bcd_t              digit_nx   [NUM_CELLS];
    logic              nonzero;
    logic              zero_next;
    logic              below_sec;

    logic       running_reg, running_next;
    logic       expired_reg, expired_next;
    logic       sel_reg, sel_next;
    logic [7:0] seg_reg, seg_next;
    logic       out_valid_reg;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign op_code  = op_t'(op);

    assign sec_sat = (seconds > sec_t'(MAX_SECONDS)) ? sec_t'(MAX_SECONDS) : seconds;
    assign sec_bcd = split_seconds(sec_t'(sec_sat + sec_t'(1)));

    assign ctl.load  = accept && (op_code == OP_START);
    assign ctl.clear = accept && (op_code == OP_STOP);

    always_comb
    begin
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            load_digit[i] = '0;
        end
        load_digit[SEC_UNITS_CELL] = sec_bcd.units;
        load_digit[SEC_TENS_CELL]  = sec_bcd.tens;
    end

    always_comb
    begin
        nonzero   = 1'b0;
        zero_next = 1'b1;
        for (int i = 0; i < NUM_CELLS; i++)
        begin
            nonzero   = nonzero || (digit_q[i] != 4'd0);
            zero_next = zero_next && (digit_nx[i] == 4'd0);
        end
    end

    assign borrow[0] = accept && (op_code == OP_TICK) && running_reg && nonzero;

    for (genvar g = 0; g < NUM_CELLS; g++)
    begin : g_cell
        ctsd_bcd_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .load_digit (load_digit[g]),
            .borrow_in  (borrow[g]),
            .borrow_out (borrow[g+1]),
            .digit_next (digit_nx[g]),
            .digit      (digit_q[g])
        );
    end

    assign below_sec = (digit_nx[SEC_TENS_CELL] == 4'd0) && (digit_nx[SEC_UNITS_CELL] == 4'd0);

    always_comb
    begin
        running_next = running_reg;
        expired_next = expired_reg;
        sel_next     = sel_reg;
        seg_next     = seg_reg;
        if (accept)
        begin
            unique case (op_code)
                OP_TICK:
                begin
                    if (running_reg && zero_next)
                    begin
                        running_next = 1'b0;
                        expired_next = 1'b1;
                    end
                    sel_next = !sel_reg;
                    if (expired_next)
                    begin
                        seg_next = sel_next ? (glyph(4'd0) | DOT_BIT) : glyph(4'd0);
                    end
                    else if (!sel_next)
                    begin
                        seg_next = below_sec ? glyph(digit_nx[TENTHS_CELL])
                                             : glyph(digit_nx[SEC_UNITS_CELL]);
                    end
                    else if (below_sec)
                    begin
                        seg_next = glyph(4'd0) | DOT_BIT;
                    end
                    else if (digit_nx[SEC_TENS_CELL] == 4'd0)
                    begin
                        seg_next = 8'd0;
                    end
                    else
                    begin
                        seg_next = glyph(digit_nx[SEC_TENS_CELL]);
                    end
                end
                OP_START:
                begin
                    running_next = 1'b1;
                    expired_next = 1'b0;
                end
                OP_PAUSE:
                begin
                    if (pause_flag)
                    begin
                        running_next = 1'b0;
                    end
                    else if (nonzero)
                    begin
                        running_next = 1'b1;
                    end
                end
                OP_STOP:
                begin
                    running_next = 1'b0;
                    expired_next = 1'b1;
                end
                default:
                begin
                    running_next = running_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            expired_reg   <= 1'b0;
            sel_reg       <= 1'b0;
            seg_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            running_reg <= running_next;
            expired_reg <= expired_next;
            sel_reg     <= sel_next;
            seg_reg     <= seg_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign segments     = seg_reg;
    assign digit_select = sel_reg;
    assign expired      = expired_reg;

endmodule

`default_nettype wire
